@@ src/slr_pkg.sv @@
// Shared types and constants for the sorted site table.
// No dependencies; used by every other file of the block.
`default_nettype none
package slr_pkg;

  localparam int CHR_W   = 8;
  localparam int POS_W   = 32;
  localparam int OUT_W   = 11;
  localparam int CHR_LIM_W = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CHR_W-1:0] chr;
    logic [POS_W-1:0] pos;
  } site_t;

  // strict: site < key, otherwise site <= key
  function automatic logic site_before(site_t site, site_t key, logic strict);
    logic res;
    if (site.chr != key.chr) begin
      res = site.chr < key.chr;
    end else if (strict) begin
      res = site.pos < key.pos;
    end else begin
      res = site.pos <= key.pos;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/sorted_location_range_query.sv @@
// Top level of the sorted site table with lower-bound range query.
// Depends on slr_pkg, slr_ram and slr_engine.
//
// Commands are taken with start while busy is low; each gives one result beat on
// out_valid, which cannot be held off. All work runs through one table RAM with a
// registered read, so the cost is set by RAM reads: a query does one binary search
// of about log2(n)+1 reads for the lower bound and, when range_end is above
// position, a second over the rest of the table. An insert searches, then moves
// every later site up one place, one site a cycle. Clear, no-op and a dropped
// insert go straight to their result beat. No clearing pass is needed after reset.
`default_nettype none
module sorted_location_range_query #(
  parameter int TABLE_DEPTH      = 1024,
  parameter int CHROMOSOME_LIMIT = 255
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_command,
  input  wire logic [slr_pkg::CHR_W-1:0] in_chromosome,
  input  wire logic [slr_pkg::POS_W-1:0] in_position,
  input  wire logic [slr_pkg::POS_W-1:0] in_range_end,
  output logic                           out_valid,
  output logic [slr_pkg::OUT_W-1:0]      out_first_index,
  output logic [slr_pkg::OUT_W-1:0]      out_match_count,
  output logic                           out_status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  slr_pkg::site_t mem_wdata, mem_rdata;

  slr_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slr_engine #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .CHROMOSOME_LIMIT (CHROMOSOME_LIMIT),
    .AW               (AW),
    .IW               (IW)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_chromosome   (in_chromosome),
    .in_position     (in_position),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_first_index (out_first_index),
    .out_match_count (out_match_count),
    .out_status      (out_status),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule
`default_nettype wire

@@ src/slr_ram.sv @@
// Site table storage: one write port, one read port, registered read data.
// Depends on slr_pkg for the entry type.
`default_nettype none
module slr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire slr_pkg::site_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output slr_pkg::site_t      rdata
);

  slr_pkg::site_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/slr_engine.sv @@
// Command sequencer: binary search, insert shift and range count over the table.
// Depends on slr_pkg; drives the ports of slr_ram.
`default_nettype none
module slr_engine #(
  parameter int TABLE_DEPTH      = 1024,
  parameter int CHROMOSOME_LIMIT = 255,
  parameter int AW               = 10,
  parameter int IW               = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_command,
  input  wire logic [slr_pkg::CHR_W-1:0] in_chromosome,
  input  wire logic [slr_pkg::POS_W-1:0] in_position,
  input  wire logic [slr_pkg::POS_W-1:0] in_range_end,
  output logic                           out_valid,
  output logic [slr_pkg::OUT_W-1:0]      out_first_index,
  output logic [slr_pkg::OUT_W-1:0]      out_match_count,
  output logic                           out_status,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output slr_pkg::site_t                 mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  wire slr_pkg::site_t            mem_rdata
);

  localparam logic [IW-1:0] FULL = IW'(TABLE_DEPTH);
  localparam logic [slr_pkg::CHR_LIM_W-1:0] CHR_LIMIT =
    slr_pkg::CHR_LIM_W'(CHROMOSOME_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_SRCH, ST_SHIFT_RD, ST_SHIFT, ST_WRITE, ST_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  slr_pkg::cmd_t               cmd_r, cmd_nxt;
  slr_pkg::site_t              key_r, key_nxt;
  logic [slr_pkg::POS_W-1:0]   end_r, end_nxt;
  logic                        phase_r, phase_nxt;
  logic [IW-1:0]               lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IW-1:0]               first_r, first_nxt, mcnt_r, mcnt_nxt;
  logic [IW-1:0]               cnt_r, cnt_nxt;
  logic                        status_r, status_nxt;
  logic [AW-1:0]               at_r, at_nxt, p_r, p_nxt;

  logic          go;
  logic [IW-1:0] l_mid, s_lo, s_hi, s_mid, idx;
  logic          srch_done;

  assign go    = slr_pkg::site_before(mem_rdata, key_r, cmd_r == slr_pkg::CMD_QUERY);
  assign l_mid = lo_r + ((hi_r - lo_r) >> 1);
  assign s_lo  = go ? mid_r + IW'(1) : lo_r;
  assign s_hi  = go ? hi_r : mid_r;
  assign s_mid = s_lo + ((s_hi - s_lo) >> 1);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    end_nxt    = end_r;
    phase_nxt  = phase_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    first_nxt  = first_r;
    mcnt_nxt   = mcnt_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    at_nxt     = at_r;
    p_nxt      = p_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    srch_done  = 1'b0;
    idx        = lo_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = slr_pkg::cmd_t'(in_command);
          key_nxt.chr = in_chromosome;
          key_nxt.pos = in_position;
          end_nxt     = in_range_end;
          phase_nxt   = 1'b0;
          lo_nxt      = '0;
          hi_nxt      = cnt_r;
          first_nxt   = '0;
          mcnt_nxt    = '0;
          status_nxt  = 1'b0;
          state_nxt   = ST_DONE;
          unique case (slr_pkg::cmd_t'(in_command))
            slr_pkg::CMD_CLEAR: cnt_nxt = '0;
            slr_pkg::CMD_INSERT: begin
              if (cnt_r == FULL) begin
                status_nxt = 1'b1;
              end else if ({{(slr_pkg::CHR_LIM_W-slr_pkg::CHR_W){1'b0}}, in_chromosome}
                           <= CHR_LIMIT) begin
                state_nxt = ST_LOOK;
              end
            end
            slr_pkg::CMD_QUERY: state_nxt = ST_LOOK;
            slr_pkg::CMD_NOP: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOOK: begin
        if (lo_r < hi_r) begin
          mem_raddr = l_mid[AW-1:0];
          mid_nxt   = l_mid;
          state_nxt = ST_SRCH;
        end else begin
          srch_done = 1'b1;
          idx       = lo_r;
        end
      end
      ST_SRCH: begin
        lo_nxt = s_lo;
        hi_nxt = s_hi;
        if (s_lo < s_hi) begin
          mem_raddr = s_mid[AW-1:0];
          mid_nxt   = s_mid;
        end else begin
          srch_done = 1'b1;
          idx       = s_lo;
        end
      end
      ST_SHIFT_RD: begin
        mem_raddr = p_r;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = p_r + AW'(1);
        mem_wdata = mem_rdata;
        if (p_r == at_r) begin
          state_nxt = ST_WRITE;
        end else begin
          p_nxt     = p_r - AW'(1);
          mem_raddr = p_r - AW'(1);
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = at_r;
        mem_wdata = key_r;
        cnt_nxt   = cnt_r + IW'(1);
        state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase

    if (srch_done) begin
      if (cmd_r == slr_pkg::CMD_INSERT) begin
        at_nxt = idx[AW-1:0];
        if (idx < cnt_r) begin
          p_nxt     = AW'(cnt_r - IW'(1));
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_WRITE;
        end
      end else if (!phase_r) begin
        first_nxt = idx;
        if (end_r > key_r.pos) begin
          key_nxt.pos = end_r;
          lo_nxt      = idx;
          hi_nxt      = cnt_r;
          phase_nxt   = 1'b1;
          state_nxt   = ST_LOOK;
        end else begin
          state_nxt = ST_DONE;
        end
      end else begin
        mcnt_nxt  = idx - first_r;
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    end_r    <= end_nxt;
    phase_r  <= phase_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    first_r  <= first_nxt;
    mcnt_r   <= mcnt_nxt;
    status_r <= status_nxt;
    at_r     <= at_nxt;
    p_r      <= p_nxt;
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = state_r == ST_DONE;
  assign out_first_index = slr_pkg::OUT_W'(first_r);
  assign out_match_count = slr_pkg::OUT_W'(mcnt_r);
  assign out_status      = status_r;

endmodule
`default_nettype wire

@@ src/slr_chk.sv @@
// Port-level checks for sorted_location_range_query, bound to the top level.
// Depends on slr_pkg for command codes and widths.
`default_nettype none
module slr_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [1:0]                in_command,
  input wire logic                      out_valid,
  input wire logic [slr_pkg::OUT_W-1:0] out_first_index,
  input wire logic [slr_pkg::OUT_W-1:0] out_match_count,
  input wire logic                      out_status
);

  // every accepted beat holds busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted command");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 (!busy && !out_valid))
    else $error("result beat outside a command");

  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("command ended without a result beat");

  a_plain_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == slr_pkg::CMD_CLEAR || in_command == slr_pkg::CMD_NOP)
    |=> out_valid && out_first_index == '0 && out_match_count == '0 && !out_status)
    else $error("clear or no-op result wrong");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_first_index == '0 && out_match_count == '0)
    else $error("dropped insert carries query fields");

endmodule

bind sorted_location_range_query slr_chk u_slr_chk (.*);
`default_nettype wire

@@ tb/sorted_location_range_query_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_location_range_query: a directed table, then
// random clear/insert/query traffic scored against a behavioural site table.
// Depends on slr_pkg and the block's RTL.
module sorted_location_range_query_test;

  localparam int TABLE_DEPTH = 1024;
  localparam int CHR_LIMIT   = 255;
  localparam int ITEM_TARGET = 1550;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [slr_pkg::POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [slr_pkg::OUT_W-1:0] first_index;
    logic [slr_pkg::OUT_W-1:0] match_count;
    logic                      status;
  } lookup_result_t;

  typedef struct {
    slr_pkg::cmd_t             cmd;
    logic [slr_pkg::CHR_W-1:0] chr;
    logic [slr_pkg::POS_W-1:0] pos;
    logic [slr_pkg::POS_W-1:0] range_end;
    bit                        pinned;
    lookup_result_t            res;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_command = slr_pkg::CMD_NOP;
  logic [slr_pkg::CHR_W-1:0] in_chromosome = '0;
  logic [slr_pkg::POS_W-1:0] in_position = '0;
  logic [slr_pkg::POS_W-1:0] in_range_end = '0;
  logic                      out_valid;
  logic [slr_pkg::OUT_W-1:0] out_first_index;
  logic [slr_pkg::OUT_W-1:0] out_match_count;
  logic                      out_status;

  // shadow site table
  logic [slr_pkg::CHR_W-1:0] site_chr_q [TABLE_DEPTH];
  logic [slr_pkg::POS_W-1:0] site_pos_q [TABLE_DEPTH];
  int unsigned               site_total = 0;
  lookup_result_t            pending_q [$];

  bit                        pinned_valid = 1'b0;
  lookup_result_t            pinned_res = '0;

  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;
  int unsigned items_done = 0;
  int unsigned results_seen = 0;
  int unsigned inserts_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned queries_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned peak_fill = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;

  sorted_location_range_query u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_chromosome   (in_chromosome),
    .in_position     (in_position),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_first_index (out_first_index),
    .out_match_count (out_match_count),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  function automatic bit orders_before(int unsigned i, logic [slr_pkg::CHR_W-1:0] chr,
                                       logic [slr_pkg::POS_W-1:0] pos, bit or_equal);
    if (site_chr_q[i] != chr) return site_chr_q[i] < chr;
    return or_equal ? (site_pos_q[i] <= pos) : (site_pos_q[i] < pos);
  endfunction

  function automatic int unsigned bound_search(logic [slr_pkg::CHR_W-1:0] chr,
                                               logic [slr_pkg::POS_W-1:0] pos,
                                               bit or_equal);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = site_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (orders_before(mid, chr, pos, or_equal)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic lookup_result_t site_table_step(slr_pkg::cmd_t cmd,
                                                     logic [slr_pkg::CHR_W-1:0] chr,
                                                     logic [slr_pkg::POS_W-1:0] pos,
                                                     logic [slr_pkg::POS_W-1:0] range_end);
    lookup_result_t res;
    int unsigned    at;
    int unsigned    idx;
    int unsigned    hits;
    res = '0;
    case (cmd)
      slr_pkg::CMD_CLEAR: begin
        site_total = 0;
      end
      slr_pkg::CMD_INSERT: begin
        if (site_total >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else if (chr <= CHR_LIMIT) begin
          at = bound_search(chr, pos, 1'b1);
          for (idx = site_total; idx > at; idx--) begin
            site_chr_q[idx] = site_chr_q[idx-1];
            site_pos_q[idx] = site_pos_q[idx-1];
          end
          site_chr_q[at] = chr;
          site_pos_q[at] = pos;
          site_total++;
        end
      end
      slr_pkg::CMD_QUERY: begin
        at = bound_search(chr, pos, 1'b0);
        hits = 0;
        idx = at;
        while (idx < site_total && site_chr_q[idx] == chr &&
               site_pos_q[idx] < range_end) begin
          hits++;
          idx++;
        end
        res.first_index = at[slr_pkg::OUT_W-1:0];
        res.match_count = hits[slr_pkg::OUT_W-1:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // scoreboard: results are retired before the new beat is predicted
  always @(posedge clk) begin : monitor
    lookup_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'(out_first_index), 32'd0);
        end else begin
          want = pending_q.pop_front();
          if (out_first_index !== want.first_index)
            report_mismatch("first_index", 32'(out_first_index), 32'(want.first_index));
          if (out_match_count !== want.match_count)
            report_mismatch("match_count", 32'(out_match_count), 32'(want.match_count));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
        end
      end
      if (start && busy === 1'b0) begin
        want = site_table_step(slr_pkg::cmd_t'(in_command), in_chromosome, in_position,
                               in_range_end);
        if (pinned_valid) want = pinned_res;
        pending_q.push_back(want);
        beats_taken++;
        if (slr_pkg::cmd_t'(in_command) != slr_pkg::CMD_NOP) items_done++;
        case (slr_pkg::cmd_t'(in_command))
          slr_pkg::CMD_INSERT: begin
            inserts_seen++;
            if (want.status) drops_seen++;
          end
          slr_pkg::CMD_QUERY: queries_seen++;
          slr_pkg::CMD_CLEAR: clears_seen++;
          default: begin
          end
        endcase
        if (site_total > peak_fill) peak_fill = site_total;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(slr_pkg::cmd_t cmd, logic [slr_pkg::CHR_W-1:0] chr,
                           logic [slr_pkg::POS_W-1:0] pos,
                           logic [slr_pkg::POS_W-1:0] range_end, bit pinned,
                           lookup_result_t res);
    int unsigned taken;
    in_command = cmd;
    in_chromosome = chr;
    in_position = pos;
    in_range_end = range_end;
    pinned_valid = pinned;
    pinned_res = res;
    start = 1'b1;
    taken = beats_taken;
    do @(negedge clk); while (beats_taken == taken);
  endtask

  task automatic hold_off(int unsigned cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic issue(slr_pkg::cmd_t cmd, logic [slr_pkg::CHR_W-1:0] chr,
                       logic [slr_pkg::POS_W-1:0] pos,
                       logic [slr_pkg::POS_W-1:0] range_end);
    send_beat(cmd, chr, pos, range_end, 1'b0, '0);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      hold_off($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6));
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [slr_pkg::POS_W-1:0] pick_position(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 24);
      1: return $urandom;
      2: return POS_MAX - $urandom_range(0, 24);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom;
    endcase
  endfunction

  function automatic logic [slr_pkg::POS_W-1:0] pick_range_end(
      logic [slr_pkg::POS_W-1:0] pos, int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return pos + $urandom_range(0, 16);
    if (roll < 55) return POS_MAX;
    if (roll < 70) return pick_position(mode);
    if (roll < 80) return pos - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [slr_pkg::CHR_W-1:0] pick_chromosome(
      logic [slr_pkg::CHR_W-1:0] base);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'(base + $urandom_range(0, 3));
  endfunction

  // small tables with clustered keys so equal keys and shared chromosomes are common
  task automatic random_segment();
    logic [slr_pkg::CHR_W-1:0] base;
    logic [slr_pkg::POS_W-1:0] qpos;
    int unsigned               mode;
    int unsigned               n_ops;
    int unsigned               roll;
    issue(slr_pkg::CMD_CLEAR, 8'($urandom), $urandom, $urandom);
    base = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'd0 : 8'd252)
                                     : 8'($urandom_range(0, 252));
    mode = $urandom_range(0, 3);
    n_ops = $urandom_range(5, 60);
    repeat (n_ops) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        issue(slr_pkg::CMD_INSERT, pick_chromosome(base), pick_position(mode), $urandom);
      end else if (roll < 90) begin
        qpos = $urandom_range(0, 9) == 0 ? '0 : pick_position(mode);
        issue(slr_pkg::CMD_QUERY, pick_chromosome(base), qpos, pick_range_end(qpos, mode));
      end else if (roll < 95) begin
        issue(slr_pkg::CMD_NOP, 8'($urandom), $urandom, $urandom);
      end else if (roll < 97) begin
        issue(slr_pkg::CMD_CLEAR, 8'($urandom), $urandom, $urandom);
      end else begin
        issue(slr_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
      end
    end
    if ($urandom_range(0, 3) == 0) drain_results();
  endtask

  // fill to capacity mostly in ascending order, then probe the full table
  task automatic fill_table();
    logic [slr_pkg::CHR_W-1:0] fill_chr;
    logic [slr_pkg::POS_W-1:0] run_pos;
    logic [slr_pkg::POS_W-1:0] qpos;
    int unsigned               roll;
    fill_chr = 8'($urandom_range(0, 255));
    run_pos = $urandom_range(0, 4000);
    issue(slr_pkg::CMD_CLEAR, fill_chr, run_pos, '0);
    while (site_total < TABLE_DEPTH) begin
      roll = $urandom_range(0, 199);
      if (roll < 6) begin
        qpos = $urandom_range(0, run_pos + 8);
        issue(slr_pkg::CMD_QUERY, fill_chr, qpos, qpos + $urandom_range(0, 300));
      end else if (roll < 8) begin
        issue(slr_pkg::CMD_INSERT, fill_chr, $urandom_range(0, run_pos), $urandom);
      end else if (roll < 9) begin
        issue(slr_pkg::CMD_INSERT, 8'($urandom), $urandom, $urandom);
      end else begin
        run_pos = run_pos + $urandom_range(0, 3);
        issue(slr_pkg::CMD_INSERT, fill_chr, run_pos, $urandom);
      end
    end
    repeat (4) issue(slr_pkg::CMD_INSERT, 8'($urandom), $urandom, $urandom);
    issue(slr_pkg::CMD_QUERY, fill_chr, '0, POS_MAX);
    issue(slr_pkg::CMD_QUERY, 8'd255, POS_MAX, POS_MAX);
    repeat (40) begin
      qpos = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, run_pos + 10);
      issue(slr_pkg::CMD_QUERY, $urandom_range(0, 9) < 7 ? fill_chr : 8'($urandom),
            qpos, $urandom_range(0, 1) ? POS_MAX : qpos + $urandom_range(0, 500));
    end
    drain_results();
  endtask

  function automatic directed_row_t row(slr_pkg::cmd_t cmd, int chr,
                                        logic [slr_pkg::POS_W-1:0] pos,
                                        logic [slr_pkg::POS_W-1:0] range_end,
                                        bit pinned = 1'b0, int first = 0, int count = 0,
                                        bit status = 1'b0);
    directed_row_t r;
    r.cmd = cmd;
    r.chr = chr[slr_pkg::CHR_W-1:0];
    r.pos = pos;
    r.range_end = range_end;
    r.pinned = pinned;
    r.res.first_index = first[slr_pkg::OUT_W-1:0];
    r.res.match_count = count[slr_pkg::OUT_W-1:0];
    r.res.status = status;
    return r;
  endfunction

  initial begin : stimulus
    directed_row_t plan [$];
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    hold_off(2);

    plan.push_back(row(slr_pkg::CMD_QUERY,  0,   '0,      POS_MAX, 1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_NOP,    255, POS_MAX, POS_MAX, 1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_CLEAR,  255, POS_MAX, POS_MAX, 1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 0,   '0,      '0,      1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 255, POS_MAX, '0,      1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 7,   100,     POS_MAX));
    plan.push_back(row(slr_pkg::CMD_INSERT, 7,   100,     '0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 7,   50,      '0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 7,   200,     '0));
    plan.push_back(row(slr_pkg::CMD_INSERT, 128, 32'h8000_0000, '0));
    plan.push_back(row(slr_pkg::CMD_QUERY,  7,   50,      201));
    plan.push_back(row(slr_pkg::CMD_QUERY,  7,   100,     100));
    plan.push_back(row(slr_pkg::CMD_QUERY,  7,   100,     99));
    plan.push_back(row(slr_pkg::CMD_QUERY,  7,   300,     POS_MAX));
    plan.push_back(row(slr_pkg::CMD_QUERY,  255, POS_MAX, POS_MAX));
    plan.push_back(row(slr_pkg::CMD_QUERY,  255, '0,      POS_MAX));
    plan.push_back(row(slr_pkg::CMD_QUERY,  0,   '0,      1));
    plan.push_back(row(slr_pkg::CMD_QUERY,  3,   '0,      POS_MAX));
    plan.push_back(row(slr_pkg::CMD_QUERY,  128, 32'h7FFF_FFFF, 32'h8000_0001));
    plan.push_back(row(slr_pkg::CMD_QUERY,  0,   POS_MAX, '0));
    plan.push_back(row(slr_pkg::CMD_NOP,    0,   '0,      '0,      1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_CLEAR,  0,   '0,      '0,      1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_QUERY,  7,   '0,      POS_MAX, 1'b1, 0, 0, 1'b0));
    plan.push_back(row(slr_pkg::CMD_QUERY,  255, POS_MAX, POS_MAX, 1'b1, 0, 0, 1'b0));

    foreach (plan[i]) begin
      send_beat(plan[i].cmd, plan[i].chr, plan[i].pos, plan[i].range_end,
                plan[i].pinned, plan[i].res);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 20));
    end
    pinned_valid = 1'b0;
    drain_results();

    while (items_done < 350) random_segment();
    drain_results();
    fill_table();
    while (items_done < ITEM_TARGET) random_segment();

    drain_results();
    hold_off(TAIL_CYCLES);
    if (pending_q.size() != 0)
      report_mismatch("results never delivered", 32'(pending_q.size()), 32'd0);

    $display("Ran %0d commands: %0d inserts (%0d refused on a full table), %0d queries,",
             beats_taken, inserts_seen, drops_seen, queries_seen);
    $display("%0d clears; table peaked at %0d of %0d sites; %0d result beats checked.",
             clears_seen, peak_fill, TABLE_DEPTH, results_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
